>>> rtl/soe_pkg.sv
// Shared types and constants for the set operation engine.
// Used by soe_controller, soe_datapath and set_operation_engine; no dependencies.
`default_nettype none

package soe_pkg;

  // Element and register widths.
  localparam int unsigned ValW       = 32;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned MaxElemsDef = 32;

  // Request codes of an input beat.
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd0;
  localparam logic [ReqW-1:0] REQ_ADD_A = 2'd1;
  localparam logic [ReqW-1:0] REQ_ADD_B = 2'd2;
  localparam logic [ReqW-1:0] REQ_RUN   = 2'd3;

  // Operation modes held in the configuration register.
  localparam logic [ModeW-1:0] MODE_UNION     = 3'd0;
  localparam logic [ModeW-1:0] MODE_INTERSECT = 3'd1;
  localparam logic [ModeW-1:0] MODE_A_MINUS_B = 3'd2;
  localparam logic [ModeW-1:0] MODE_B_MINUS_A = 3'd3;
  localparam logic [ModeW-1:0] MODE_SYM_DIFF  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;      // empty both sets
    logic wr_a;       // append the input value to set A
    logic wr_b;       // append the input value to set B
    logic src_b;      // the set being walked is B (otherwise A)
    logic latch_cur;  // capture the source element just read
    logic push_cur;   // move pending element out, make current one pending
    logic finish;     // emit pending element as last, or the empty marker
  } soe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_eq;     // current element equals the other set's read data
    logic pend_valid; // an element waits to be emitted
    logic out_free;   // the output register can take a beat this cycle
  } soe_status_t;

endpackage

`default_nettype wire

>>> rtl/soe_datapath.sv
// Datapath of the set operation engine: both set memories, counts, compare,
// pending element and output register. Depends on soe_pkg.
`default_nettype none

module soe_datapath #(
  parameter int unsigned MaxElems = 32,
  parameter int unsigned IdxW     = 5,
  parameter int unsigned CntW     = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  soe_pkg::soe_cmd_t            cmd_i,
  output soe_pkg::soe_status_t         status_o,
  input  logic [IdxW-1:0]              rd_addr_a_i,
  input  logic [IdxW-1:0]              rd_addr_b_i,
  output logic [CntW-1:0]              count_a_o,
  output logic [CntW-1:0]              count_b_o,
  input  logic signed [soe_pkg::ValW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [soe_pkg::ValW-1:0] elem_value_o,
  output logic                         elem_valid_o,
  output logic                         last_elem_o
);
  import soe_pkg::*;

  logic [ValW-1:0] mem_a [MaxElems];
  logic [ValW-1:0] mem_b [MaxElems];
  logic [ValW-1:0] rd_a_q, rd_b_q;
  logic [ValW-1:0] cur_q, pend_q;
  logic            pend_valid_q, pend_valid_d;
  logic [CntW-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] out_value_q;
  logic            out_elem_q, out_last_q;
  logic            out_take, out_load;
  logic [ValW-1:0] other_rd;

  // Set memories: append at the fill count, one registered read each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[count_a_q[IdxW-1:0]] <= value_i;
    end
    if (cmd_i.wr_b) begin
      mem_b[count_b_q[IdxW-1:0]] <= value_i;
    end
    rd_a_q <= mem_a[rd_addr_a_i];
    rd_b_q <= mem_b[rd_addr_b_i];
  end

  // Fill counts.
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    if (cmd_i.clear) begin
      count_a_d = '0;
      count_b_d = '0;
    end else begin
      if (cmd_i.wr_a) count_a_d = count_a_q + 1'b1;
      if (cmd_i.wr_b) count_b_d = count_b_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
    end
  end

  // Current source element and its compare against the other set.
  assign other_rd = cmd_i.src_b ? rd_a_q : rd_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_cur) begin
      cur_q <= cmd_i.src_b ? rd_b_q : rd_a_q;
    end
    if (cmd_i.push_cur) begin
      pend_q <= cur_q;
    end
  end

  // The pending element is held back until the next one, or the end of the
  // run, shows whether it is the last.
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.push_cur) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.finish) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  // Output register: loaded on a push with a pending element, or on finish.
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_load    = (cmd_i.push_cur && pend_valid_q) || cmd_i.finish;
  assign out_valid_d = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= pend_valid_q ? pend_q : '0;
      out_elem_q  <= pend_valid_q;
      out_last_q  <= cmd_i.finish;
    end
  end

  assign status_o.cmp_eq     = (cur_q == other_rd);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign count_a_o    = count_a_q;
  assign count_b_o    = count_b_q;
  assign out_valid_o  = out_valid_q;
  assign elem_value_o = out_value_q;
  assign elem_valid_o = out_elem_q;
  assign last_elem_o  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/soe_controller.sv
// Controller of the set operation engine: mode register, input acceptance and
// the state machine that walks the sets. Depends on soe_pkg.
`default_nettype none

module soe_controller #(
  parameter int unsigned MaxElems = 32,
  parameter int unsigned IdxW     = 5,
  parameter int unsigned CntW     = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [soe_pkg::ModeW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [soe_pkg::ReqW-1:0]      req_type_i,
  output soe_pkg::soe_cmd_t             cmd_o,
  input  soe_pkg::soe_status_t          status_i,
  input  logic [CntW-1:0]               count_a_i,
  input  logic [CntW-1:0]               count_b_i,
  output logic [IdxW-1:0]               rd_addr_a_o,
  output logic [IdxW-1:0]               rd_addr_b_o
);
  import soe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam logic [CntW-1:0] Full = CntW'(MaxElems);

  logic [2:0]       state_q, state_d;
  logic [ModeW-1:0] op_mode_q;
  logic             pass_q, pass_d;
  logic [CntW-1:0]  i_q, i_d, j_q, j_d, j_next;
  logic             found_q, found_d;
  logic             accept;
  logic             p_src_b, p_keep, p_all, p_more, p_none;
  logic [CntW-1:0]  n_src, n_oth;
  logic [IdxW-1:0]  src_addr, oth_addr;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= MODE_UNION;
    end else if (cfg_we_i) begin
      op_mode_q <= cfg_wdata_i;
    end
  end

  // Pass table: which set is walked, against which, and what is kept.
  always_comb begin
    p_src_b = 1'b0;
    p_keep  = 1'b0;
    p_all   = 1'b0;
    p_more  = 1'b0;
    p_none  = 1'b0;
    case (op_mode_q)
      MODE_UNION: begin
        p_all   = !pass_q;
        p_src_b = pass_q;
        p_more  = !pass_q;
      end
      MODE_INTERSECT: begin
        p_src_b = 1'b1;
        p_keep  = 1'b1;
      end
      MODE_A_MINUS_B: begin
        p_src_b = 1'b0;
      end
      MODE_B_MINUS_A: begin
        p_src_b = 1'b1;
      end
      MODE_SYM_DIFF: begin
        p_src_b = pass_q;
        p_more  = !pass_q;
      end
      default: begin
        p_none = 1'b1;
      end
    endcase
  end

  assign n_src  = p_src_b ? count_b_i : count_a_i;
  assign n_oth  = p_src_b ? count_a_i : count_b_i;
  assign j_next = j_q + 1'b1;

  // The source set is read at i, the other set at the next compare index.
  assign src_addr    = i_q[IdxW-1:0];
  assign oth_addr    = (state_q == ST_CMP) ? j_next[IdxW-1:0] : '0;
  assign rd_addr_a_o = p_src_b ? oth_addr : src_addr;
  assign rd_addr_b_o = p_src_b ? src_addr : oth_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequencer: one source element per fetch, one compare per cycle.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    i_d     = i_q;
    j_d     = j_q;
    found_d = found_q;
    cmd_o   = '0;
    cmd_o.src_b = p_src_b;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_CLEAR: cmd_o.clear = 1'b1;
            REQ_ADD_A: cmd_o.wr_a = (count_a_i != Full);
            REQ_ADD_B: cmd_o.wr_b = (count_b_i != Full);
            default: begin
              pass_d  = 1'b0;
              i_d     = '0;
              state_d = p_none ? ST_FINISH : ST_FETCH;
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (i_q == n_src) begin
          if (p_more) begin
            pass_d = 1'b1;
            i_d    = '0;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.latch_cur = 1'b1;
        j_d = '0;
        if (p_all || n_oth == '0) begin
          found_d = 1'b0;
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.cmp_eq) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else if (j_next == n_oth) begin
          found_d = 1'b0;
          state_d = ST_DECIDE;
        end else begin
          j_d = j_next;
        end
      end
      ST_DECIDE: begin
        if (p_all || (found_q == p_keep)) begin
          if (!status_i.pend_valid || status_i.out_free) begin
            cmd_o.push_cur = 1'b1;
            i_d     = i_q + 1'b1;
            state_d = ST_FETCH;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      i_q     <= i_d;
      j_q     <= j_d;
      found_q <= found_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/set_operation_engine.sv
// Set operation engine: holds two sets A and B of up to MaxElems signed 32-bit
// values and streams union, intersection, A minus B, B minus A or symmetric
// difference on a run beat. A load into a full set is dropped. A run stalls
// the input until its last result beat is in the output register. Each
// element of the walked set passes through the fetch, load and decide states,
// with one compare state per compare against the other set between load and
// decide. The walk stops at the first match, and there are no compares in the
// first pass of a union or when the other set is empty. Each pass ends with
// one more fetch, so union and symmetric difference spend two such fetches. A
// finish state then closes the run. An undefined mode goes straight from the
// accepted run beat to the finish state. A decide that must emit an element
// while another is pending, and the finish state, wait while the output
// register holds a stalled beat. The worst case is about count_a * count_b
// compares, set by the single read port of each set memory. An empty result
// gives one beat with elem_valid_o low and last_elem_o high. Depends on
// soe_pkg, soe_controller and soe_datapath.
`default_nettype none

module set_operation_engine #(
  parameter int unsigned MaxElems = soe_pkg::MaxElemsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [soe_pkg::ModeW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [soe_pkg::ReqW-1:0]        req_type_i,
  input  logic signed [soe_pkg::ValW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [soe_pkg::ValW-1:0] elem_value_o,
  output logic                            elem_valid_o,
  output logic                            last_elem_o
);
  import soe_pkg::*;

  localparam int unsigned IdxW = (MaxElems > 1) ? $clog2(MaxElems) : 1;
  localparam int unsigned CntW = $clog2(MaxElems + 1);

  soe_cmd_t        cmd;
  soe_status_t     status;
  logic [IdxW-1:0] rd_addr_a, rd_addr_b;
  logic [CntW-1:0] count_a, count_b;

  soe_controller #(
    .MaxElems(MaxElems),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .count_a_i   (count_a),
    .count_b_i   (count_b),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b)
  );

  soe_datapath #(
    .MaxElems(MaxElems),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .rd_addr_a_i  (rd_addr_a),
    .rd_addr_b_i  (rd_addr_b),
    .count_a_o    (count_a),
    .count_b_o    (count_b),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .elem_value_o (elem_value_o),
    .elem_valid_o (elem_valid_o),
    .last_elem_o  (last_elem_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/set_operation_engine_tb.sv
// Self-checking testbench for set_operation_engine: loads sets A and B, runs every
// operation mode and compares each streamed result beat with an in-bench predictor.
// Depends on soe_pkg and the set_operation_engine RTL only.
module set_operation_engine_tb;
  import soe_pkg::*;

  localparam int unsigned MaxElems     = MaxElemsDef;
  localparam int unsigned QuietLimit   = 20000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned Segments     = 10;
  localparam int unsigned SegmentItems = 20;
  localparam int unsigned PoolSize     = 8;
  localparam int unsigned PrintCap     = 100;

  // One request beat as queued for the driver.
  typedef struct packed {
    logic [ReqW-1:0]        req;
    logic signed [ValW-1:0] value;
  } req_beat_t;

  // One result beat as the block should emit it.
  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   valid;
    logic                   last;
  } elem_beat_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [ModeW-1:0]       cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [ReqW-1:0]        req_type_i  = '0;
  logic signed [ValW-1:0] value_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [ValW-1:0] elem_value_o;
  logic                   elem_valid_o;
  logic                   last_elem_o;

  // Predictor copy of the block state.
  logic signed [ValW-1:0] set_a_copy [MaxElems];
  logic signed [ValW-1:0] set_b_copy [MaxElems];
  int unsigned            fill_a    = 0;
  int unsigned            fill_b    = 0;
  logic [ModeW-1:0]       mode_copy = MODE_UNION;

  req_beat_t              pending_reqs [$];
  elem_beat_t             expected_elems [$];
  logic signed [ValW-1:0] run_values [$];
  logic signed [ValW-1:0] draw_pool [PoolSize];

  logic        in_taken       = 1'b0;
  int unsigned send_idle_pct  = 12;
  int unsigned recv_idle_pct  = 78;
  int unsigned items_queued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  set_operation_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .elem_value_o (elem_value_o),
    .elem_valid_o (elem_valid_o),
    .last_elem_o  (last_elem_o)
  );

  always #5 clk_i = ~clk_i;

  // Mismatch reporting: one line per failure, printing capped to keep the log short.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // True when v is stored in the first fill entries of set B (in_b) or set A.
  function automatic bit holds(input bit in_b, input logic [ValW-1:0] v);
    int unsigned n;
    n = in_b ? fill_b : fill_a;
    for (int unsigned i = 0; i < n; i++) begin
      if ((in_b ? set_b_copy[i] : set_a_copy[i]) == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Walk one set in load order and keep the elements that are (or are not) in the other.
  task automatic walk_set(input bit walk_b, input bit keep_found);
    logic signed [ValW-1:0] v;
    int unsigned            n;
    n = walk_b ? fill_b : fill_a;
    for (int unsigned i = 0; i < n; i++) begin
      v = walk_b ? set_b_copy[i] : set_a_copy[i];
      if (holds(!walk_b, v) == keep_found) run_values.push_back(v);
    end
  endtask

  // Apply one accepted request beat and queue the result beats it causes.
  task automatic predict_beat(input req_beat_t b);
    run_values.delete();
    case (b.req)
      REQ_CLEAR: begin
        fill_a = 0;
        fill_b = 0;
      end
      REQ_ADD_A: begin
        if (fill_a < MaxElems) begin
          set_a_copy[fill_a] = b.value;
          fill_a++;
        end
      end
      REQ_ADD_B: begin
        if (fill_b < MaxElems) begin
          set_b_copy[fill_b] = b.value;
          fill_b++;
        end
      end
      REQ_RUN: begin
        case (mode_copy)
          MODE_UNION: begin
            for (int unsigned i = 0; i < fill_a; i++) run_values.push_back(set_a_copy[i]);
            walk_set(1'b1, 1'b0);
          end
          MODE_INTERSECT: walk_set(1'b1, 1'b1);
          MODE_A_MINUS_B: walk_set(1'b0, 1'b0);
          MODE_B_MINUS_A: walk_set(1'b1, 1'b0);
          MODE_SYM_DIFF: begin
            walk_set(1'b0, 1'b0);
            walk_set(1'b1, 1'b0);
          end
          default: ;
        endcase
        // An empty result still gives one marker beat.
        if (run_values.size() == 0) begin
          expected_elems.push_back('{'0, 1'b0, 1'b1});
        end else begin
          foreach (run_values[i]) begin
            expected_elems.push_back('{run_values[i], 1'b1, i == run_values.size() - 1});
          end
        end
      end
    endcase
  endtask

  // Compare one accepted result beat with the oldest expectation.
  task automatic check_elem();
    elem_beat_t want;
    if (expected_elems.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: value=%0d valid=%0b last=%0b",
                                elem_value_o, elem_valid_o, last_elem_o));
      return;
    end
    want = expected_elems.pop_front();
    if (elem_value_o !== want.value) begin
      report_mismatch($sformatf("elem_value got %0d want %0d", elem_value_o, want.value));
    end
    if (elem_valid_o !== want.valid) begin
      report_mismatch($sformatf("elem_valid got %0b want %0b", elem_valid_o, want.valid));
    end
    if (last_elem_o !== want.last) begin
      report_mismatch($sformatf("last_elem got %0b want %0b", last_elem_o, want.last));
    end
  endtask

  // Driver: a new beat only after the previous one was taken; stall is random per cycle.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        req_type_i <= pending_reqs[0].req;
        value_i    <= pending_reqs[0].value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predict on each accepted request beat, check each accepted result beat.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_beat(pending_reqs.pop_front());
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_elem();
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(ValW-1){1'b0}}};
      1:       return {1'b0, {(ValW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly reuse values from a small pool so that sets overlap and hold duplicates.
  function automatic logic [ValW-1:0] draw_element();
    if ($urandom_range(0, 9) < 7) return draw_pool[$urandom_range(0, PoolSize - 1)];
    return pick_value();
  endfunction

  task automatic queue_req(input logic [ReqW-1:0] r, input logic [ValW-1:0] v);
    pending_reqs.push_back('{r, v});
    items_queued++;
  endtask

  // Wait until every beat is sent and every result is back, then let the block go idle.
  task automatic settle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_elems.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write while the block is idle; the predictor takes it at the same edge.
  task automatic set_mode(input logic [ModeW-1:0] m);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    mode_copy = m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random sequence: mostly clear, loads with overlapping values and runs; some noise.
  task automatic build_sequence();
    int unsigned kind;
    int unsigned n_a;
    int unsigned n_b;
    kind = $urandom_range(0, 9);
    foreach (draw_pool[i]) draw_pool[i] = pick_value();
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) queue_req(ReqW'($urandom_range(0, 3)), pick_value());
    end else begin
      // Now and then build on top of what the sets already hold.
      if (kind != 1) queue_req(REQ_CLEAR, $urandom);
      n_a = ($urandom_range(0, 11) == 0) ? $urandom_range(MaxElems - 4, MaxElems + 4)
                                         : $urandom_range(0, 6);
      n_b = ($urandom_range(0, 11) == 0) ? $urandom_range(MaxElems - 4, MaxElems + 4)
                                         : $urandom_range(0, 6);
      while (n_a + n_b > 0) begin
        if (n_b == 0 || (n_a != 0 && $urandom_range(0, 1) == 1)) begin
          queue_req(REQ_ADD_A, draw_element());
          n_a--;
        end else begin
          queue_req(REQ_ADD_B, draw_element());
          n_b--;
        end
      end
      repeat ($urandom_range(1, 2)) queue_req(REQ_RUN, $urandom);
    end
  endtask

  // Stimulus: reset, directed beats over every mode, then random segments.
  initial begin
    int unsigned seg_start;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run on empty sets under the reset mode gives the empty marker.
    queue_req(REQ_RUN, $urandom);
    queue_req(REQ_CLEAR, $urandom);
    queue_req(REQ_ADD_A, {1'b1, {(ValW-1){1'b0}}});
    queue_req(REQ_ADD_A, {1'b0, {(ValW-1){1'b1}}});
    queue_req(REQ_ADD_A, '0);
    queue_req(REQ_ADD_A, '0);
    queue_req(REQ_ADD_A, 7);
    queue_req(REQ_ADD_B, '1);
    queue_req(REQ_ADD_B, 7);
    queue_req(REQ_ADD_B, {1'b1, {(ValW-1){1'b0}}});
    queue_req(REQ_ADD_B, 12345);
    // Same sets under every mode, the undefined ones included.
    for (int m = 0; m < (1 << ModeW); m++) begin
      set_mode(ModeW'(m));
      queue_req(REQ_RUN, $urandom);
    end
    // Equal one-element sets: empty symmetric difference, one-element intersection.
    queue_req(REQ_CLEAR, $urandom);
    queue_req(REQ_ADD_A, '1);
    queue_req(REQ_ADD_B, '1);
    queue_req(REQ_RUN, $urandom);
    set_mode(MODE_SYM_DIFF);
    queue_req(REQ_RUN, $urandom);
    set_mode(MODE_INTERSECT);
    queue_req(REQ_RUN, $urandom);

    // Random segments, each under one mode; idling pattern changes by phase.
    for (int unsigned seg = 0; seg < Segments; seg++) begin
      if (seg == 4) begin
        settle();
        send_idle_pct = 78;
        recv_idle_pct = 12;
      end else if (seg == 7) begin
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg < 5) begin
        set_mode(ModeW'(seg));
      end else if (seg == Segments - 1) begin
        set_mode('1);
      end else begin
        set_mode(ModeW'($urandom_range(0, (1 << ModeW) - 1)));
      end
      seg_start = items_queued;
      while (items_queued - seg_start < SegmentItems) build_sequence();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
